[hdl/lsmp_pkg.sv]
// ----------------------------------------------------------------------------
// lsmp_pkg
// Shared types and constants of the laser-scan sector minimum profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package lsmp_pkg;

	localparam int RANGE_W     = 20;  // width of range fields on the ports
	localparam int ANGLE_W     = 16;  // binary angle, 65536 units per turn
	localparam int SECTOR_W    = 4;   // enough for up to sixteen sectors
	localparam int OUT_SECTORS = 8;   // sectors reported in every result
	localparam int WIDEST_W    = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 20;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 168;

	localparam logic [RANGE_W-1:0] SENTINEL_MM = RANGE_W'(999000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_FLOOR   = 4'd0,
		CFG_RANGE_CEILING = 4'd1,
		CFG_ANGLE_START   = 4'd2,
		CFG_ANGLE_STEP    = 4'd3
	} lsmp_cfg_idx_t;

	// one classified sample between front and back
	typedef struct packed {
		logic                keep;
		logic [SECTOR_W-1:0] sector;
		logic [RANGE_W-1:0]  range_mm;
		logic                last;
	} lsmp_item_t;

	// end-of-scan snapshot handed to the report stage
	typedef struct packed {
		logic                                  valid;
		logic [OUT_SECTORS-1:0][RANGE_W-1:0]   mins;
	} lsmp_snap_t;

endpackage

`default_nettype wire

[hdl/lsmp_front.sv]
// ----------------------------------------------------------------------------
// lsmp_front
// Configuration registers, sample window check and sector classification.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmp_front #(
	parameter int NUM_SECTORS = 8,
	parameter int RANGE_BITS  = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [lsmp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsmp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	input  wire logic [lsmp_pkg::RANGE_W-1:0]    in_range_mm,
	input  wire logic                            in_finite,
	input  wire logic                            in_last,
	input  wire logic                            queue_full,
	output logic                                 in_ready,
	output logic                                 push,
	output lsmp_pkg::lsmp_item_t                 push_item
);
	import lsmp_pkg::*;

	localparam int RW = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
	localparam logic [RANGE_W-1:0] RANGE_MASK = RANGE_W'((64'(1) << RW) - 64'(1));
	localparam int PROD_W = ANGLE_W + SECTOR_W;

	logic [RANGE_W-1:0] floor_q;
	logic [RANGE_W-1:0] ceiling_q;
	logic [ANGLE_W-1:0] start_q;
	logic [ANGLE_W-1:0] step_q;
	logic [ANGLE_W-1:0] offset_q;

	logic [RANGE_W-1:0] range_m;
	logic [ANGLE_W-1:0] angle;
	logic [ANGLE_W-1:0] shifted;
	logic [PROD_W-1:0]  product;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= '0;
			ceiling_q <= RANGE_MASK;
			start_q   <= ANGLE_W'(16'h8000);
			step_q    <= ANGLE_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RANGE_FLOOR:   floor_q   <= cfg_data & RANGE_MASK;
				CFG_RANGE_CEILING: ceiling_q <= cfg_data & RANGE_MASK;
				CFG_ANGLE_START:   start_q   <= cfg_data[ANGLE_W-1:0];
				CFG_ANGLE_STEP:    step_q    <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// advance the scan angle on every sample, kept or dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (accept) begin
			offset_q <= in_last ? '0 : offset_q + step_q;
		end
	end

	always_comb begin
		range_m = in_range_mm & RANGE_MASK;
		angle   = start_q + offset_q;
		// half a turn flips the top bit
		shifted = {~angle[ANGLE_W-1], angle[ANGLE_W-2:0]};
		product = PROD_W'(shifted) * PROD_W'(NUM_SECTORS);

		push_item.keep     = in_finite && (range_m >= floor_q) && (range_m <= ceiling_q);
		push_item.sector   = product[PROD_W-1 -: SECTOR_W];
		push_item.range_mm = range_m;
		push_item.last     = in_last;
	end

	assign push = accept;

endmodule

`default_nettype wire

[hdl/lsmp_queue.sv]
// ----------------------------------------------------------------------------
// lsmp_queue
// Four-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmp_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire lsmp_pkg::lsmp_item_t push_item,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      empty,
	output lsmp_pkg::lsmp_item_t      head
);
	import lsmp_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	lsmp_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/lsmp_back.sv]
// ----------------------------------------------------------------------------
// lsmp_back
// Per-sector minimum registers; snapshots and restarts at the end of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmp_back #(
	parameter int NUM_SECTORS = 8,
	parameter int RANGE_BITS  = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 empty,
	input  wire lsmp_pkg::lsmp_item_t head,
	input  wire logic                 snap_ready,
	output logic                      pop,
	output lsmp_pkg::lsmp_snap_t      snap_s1
);
	import lsmp_pkg::*;

	localparam int RW = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
	localparam int SW = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
	localparam logic [RW-1:0] SENTINEL = (RW == RANGE_W) ? RW'(SENTINEL_MM) : {RW{1'b1}};

	logic [RW-1:0] min_q [NUM_SECTORS];
	logic [SW-1:0] idx;
	logic [RW-1:0] range_rw;
	logic          upd;
	logic          take;
	logic [OUT_SECTORS-1:0][RANGE_W-1:0] merged;
	logic                                snap_valid_s1;
	logic [OUT_SECTORS-1:0][RANGE_W-1:0] snap_mins_s1;

	assign snap_s1  = {snap_valid_s1, snap_mins_s1};

	assign idx      = head.sector[SW-1:0];
	assign range_rw = head.range_mm[RW-1:0];
	assign upd      = head.keep && (range_rw < min_q[idx]);
	// hold the queue while a finished snapshot waits
	assign pop      = !empty && (!snap_valid_s1 || snap_ready);
	assign take     = pop && head.last;

	for (genvar g = 0; g < OUT_SECTORS; g++) begin : g_merge
		if (g < NUM_SECTORS) begin : g_real
			assign merged[g] = RANGE_W'((upd && (idx == SW'(g))) ? range_rw : min_q[g]);
		end else begin : g_none
			assign merged[g] = RANGE_W'(SENTINEL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SECTORS; i++) begin
				min_q[i] <= SENTINEL;
			end
		end else if (pop) begin
			if (head.last) begin
				for (int i = 0; i < NUM_SECTORS; i++) begin
					min_q[i] <= SENTINEL;
				end
			end else if (upd) begin
				min_q[idx] <= range_rw;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (take) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			snap_mins_s1 <= merged;
		end
	end

endmodule

`default_nettype wire

[hdl/lsmp_report.sv]
// ----------------------------------------------------------------------------
// lsmp_report
// Widest-sector search and left/right comparison into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmp_report (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lsmp_pkg::lsmp_snap_t             snap_s1,
	output logic                                  snap_ready,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [lsmp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
	import lsmp_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - OUT_SECTORS*RANGE_W - WIDEST_W - 1;

	logic [RANGE_W-1:0]  lvl1_val [4];
	logic [WIDEST_W-1:0] lvl1_idx [4];
	logic [RANGE_W-1:0]  lvl2_val [2];
	logic [WIDEST_W-1:0] lvl2_idx [2];
	logic [WIDEST_W-1:0] widest;
	logic [RANGE_W:0]    left_sum;
	logic [RANGE_W:0]    right_sum;
	logic                escape_left;

	// pairwise tree; a tie keeps the lower sector
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (snap_s1.mins[2*i+1] > snap_s1.mins[2*i]) begin
				lvl1_val[i] = snap_s1.mins[2*i+1];
				lvl1_idx[i] = WIDEST_W'(2*i+1);
			end else begin
				lvl1_val[i] = snap_s1.mins[2*i];
				lvl1_idx[i] = WIDEST_W'(2*i);
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (lvl1_val[2*i+1] > lvl1_val[2*i]) begin
				lvl2_val[i] = lvl1_val[2*i+1];
				lvl2_idx[i] = lvl1_idx[2*i+1];
			end else begin
				lvl2_val[i] = lvl1_val[2*i];
				lvl2_idx[i] = lvl1_idx[2*i];
			end
		end
		widest = (lvl2_val[1] > lvl2_val[0]) ? lvl2_idx[1] : lvl2_idx[0];

		left_sum    = {1'b0, snap_s1.mins[2]} + {1'b0, snap_s1.mins[3]};
		right_sum   = {1'b0, snap_s1.mins[6]} + {1'b0, snap_s1.mins[7]};
		escape_left = left_sum > right_sum;
	end

	assign snap_ready = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (snap_ready) begin
			m_axis_tvalid <= snap_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_s1.valid) begin
			m_axis_tdata <= {PAD_W'(0), escape_left, widest, snap_s1.mins};
		end
	end

endmodule

`default_nettype wire

[hdl/lidar_sector_min_profile.sv]
// ----------------------------------------------------------------------------
// lidar_sector_min_profile
// Per-sector minimum range of a laser scan, reported once per scan.
// ----------------------------------------------------------------------------
// Input stream: one range sample per request; tuser flags a finite sample,
// tlast marks the final sample of a scan. Samples outside the configured
// range window, or not finite, are dropped but still advance the scan angle.
// Output stream: one request per scan carrying all eight sector minima, the
// widest sector and the escape-left flag.
// Configuration: cfg_valid/cfg_ready with a register index and write data;
// write only while the block is idle. cfg_ready is always high.
// Throughput: one sample per cycle while the queue is not full, set by the
// minimum update in the back end. The last sample of a scan passes the
// queue write at acceptance, the snapshot register and the output register
// before its result can be taken; a stalled receiver holds it on the way.
// Reset clears the minima to the sentinel, the scan angle to zero and the
// registers to their defaults. When the receiver stalls the result holds,
// the back end stops popping and the four-entry queue fills before
// s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_sector_min_profile #(
	parameter int NUM_SECTORS = 8,
	parameter int RANGE_BITS  = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lsmp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsmp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [lsmp_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // range_mm
	input  wire logic                            s_axis_tuser,  // is_finite
	input  wire logic                            s_axis_tlast,  // last_sample
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// min_sector0..min_sector7, widest_sector, escape_left
	output logic [lsmp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import lsmp_pkg::*;

	logic       queue_full;
	logic       queue_empty;
	logic       push;
	logic       pop;
	logic       snap_ready;
	lsmp_item_t push_item;
	lsmp_item_t head;
	lsmp_snap_t snap_s1;

	assign cfg_ready = 1'b1;

	lsmp_front #(
		.NUM_SECTORS(NUM_SECTORS),
		.RANGE_BITS (RANGE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_range_mm(s_axis_tdata[RANGE_W-1:0]),
		.in_finite  (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.queue_full (queue_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.push_item  (push_item)
	);

	lsmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head)
	);

	lsmp_back #(
		.NUM_SECTORS(NUM_SECTORS),
		.RANGE_BITS (RANGE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (queue_empty),
		.head      (head),
		.snap_ready(snap_ready),
		.pop       (pop),
		.snap_s1   (snap_s1)
	);

	lsmp_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_s1      (snap_s1),
		.snap_ready   (snap_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the laser-scan sector minimum profiler.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream and scan reports come out on the master
// stream. A predictor folds every accepted sample into its own copy of the
// sector minima and the scan angle and queues a report at each end of scan.
// Every report that comes out is checked field by field against the oldest
// queued one. A directed table covers reset defaults, range extremes, the
// window bounds, an inverted window, angle wrap and all-zero minima. Random
// scans follow under changing register settings and idle patterns, with one
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lsmp_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 10;    // last sample through queue and report
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int QUIET_LIMIT = 2000;    // cycles with no handshake at all
	localparam int PHASE_ITEMS = 95;
	localparam int PRESSURE_ITEMS = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(9);

	typedef struct packed {
		logic                                escape;
		logic [WIDEST_W-1:0]                 widest;
		logic [OUT_SECTORS-1:0][RANGE_W-1:0] mins;
	} scan_report_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [RANGE_W-1:0]    range_mm;
		logic                  finite;
		logic                  last;
		bit                    typed;
		scan_report_t          want;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // range_mm
	logic                   s_axis_tuser = 1'b0; // is_finite
	logic                   s_axis_tlast = 1'b0; // last_sample
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// min_sector0..min_sector7, widest_sector, escape_left
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor state
	logic [RANGE_W-1:0]  pred_min [OUT_SECTORS];
	logic [ANGLE_W-1:0]  pred_offset;
	logic [RANGE_W-1:0]  reg_floor;
	logic [RANGE_W-1:0]  reg_ceil;
	logic [ANGLE_W-1:0]  reg_start;
	logic [ANGLE_W-1:0]  reg_step;

	scan_report_t report_q [$];
	int unsigned  errors = 0;
	int unsigned  src_idle_pct = 0;
	int unsigned  sink_idle_pct = 0;
	logic         hold_flip = 1'b0;
	logic         hold_seen = 1'b0;
	int unsigned  hold_left = 0;
	int unsigned  quiet = 0;

	lidar_sector_min_profile uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic void restart_scan();
		for (int i = 0; i < OUT_SECTORS; i++)
			pred_min[i] = SENTINEL_MM;
		pred_offset = '0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_RANGE_FLOOR: begin
				reg_floor = val[RANGE_W-1:0];
			end
			CFG_RANGE_CEILING: begin
				reg_ceil = val[RANGE_W-1:0];
			end
			CFG_ANGLE_START: begin
				reg_start = val[ANGLE_W-1:0];
			end
			CFG_ANGLE_STEP: begin
				reg_step = val[ANGLE_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Fold one sample into the minima; at end of scan build the report.
	function automatic bit fold_sample(input logic [RANGE_W-1:0] rng, input logic fin,
	                                   input logic lst, output scan_report_t rep);
		logic [ANGLE_W-1:0] angle;
		logic [2:0]         sector;
		logic [RANGE_W-1:0] best_val;
		logic [RANGE_W:0]   left_sum;
		logic [RANGE_W:0]   right_sum;
		rep = '0;
		if (fin && rng >= reg_floor && rng <= reg_ceil) begin
			// add a half turn so the top bits give the sector directly
			angle = reg_start + pred_offset + ANGLE_W'(16'h8000);
			sector = angle[ANGLE_W-1 -: 3];
			if (rng < pred_min[sector])
				pred_min[sector] = rng;
		end
		pred_offset = pred_offset + reg_step;
		if (!lst)
			return 1'b0;
		best_val = '0;
		for (int i = 0; i < OUT_SECTORS; i++) begin
			rep.mins[i] = pred_min[i];
			if (pred_min[i] > best_val) begin
				best_val = pred_min[i];
				rep.widest = WIDEST_W'(i);
			end
		end
		left_sum = {1'b0, pred_min[2]} + {1'b0, pred_min[3]};
		right_sum = {1'b0, pred_min[6]} + {1'b0, pred_min[7]};
		rep.escape = left_sum > right_sum;
		restart_scan();
		return 1'b1;
	endfunction

	function automatic scan_report_t flat_report(input logic [RANGE_W-1:0] v,
	                                             input logic [WIDEST_W-1:0] w,
	                                             input logic e);
		scan_report_t r;
		for (int i = 0; i < OUT_SECTORS; i++)
			r.mins[i] = v;
		r.widest = w;
		r.escape = e;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
	                                      input logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = val;
		return r;
	endfunction

	function automatic plan_row_t sample_row(input logic [RANGE_W-1:0] rng,
	                                         input logic fin, input logic lst);
		plan_row_t r;
		r = '{default: '0};
		r.range_mm = rng;
		r.finite = fin;
		r.last = lst;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [RANGE_W-1:0] rng, input logic fin,
	                                        input logic lst, input scan_report_t want);
		plan_row_t r;
		r = sample_row(rng, fin, lst);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	// Leave cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, val);
	endtask

	task automatic push_sample(input logic [RANGE_W-1:0] rng, input logic fin,
	                           input logic lst, input bit typed, input scan_report_t want);
		scan_report_t rep;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(rng);
		s_axis_tuser <= fin;
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (fold_sample(rng, fin, lst, rep))
			report_q.push_back(typed ? want : rep);
	endtask

	// Drop the request and wait until the block has gone idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic randomise_regs();
		logic [CFG_DATA_W-1:0] a, b, lo, hi;
		logic [ANGLE_W-1:0]    start, step;
		a = CFG_DATA_W'($urandom);
		b = CFG_DATA_W'($urandom);
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case ($urandom_range(0, 9))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				lo = '1;
				hi = '1;
			end
			2: begin
				lo = '0;
				hi = '0;
			end
			3: begin
				// inverted window
				lo = (a < b) ? b : a;
				hi = (a < b) ? a : b;
			end
			4: lo = '0;
			5: hi = '1;
			default: begin
			end
		endcase
		case ($urandom_range(0, 3))
			0: start = ANGLE_W'(16'h8000);
			1: start = ANGLE_W'(16'h7FFF);
			default: start = ANGLE_W'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: step = '0;
			1: step = ANGLE_W'(16'h2000);
			2: step = ANGLE_W'(16'h8000);
			3: step = ANGLE_W'(16'h7FFF);
			4: step = ANGLE_W'(16'hFFFF);
			default: step = ANGLE_W'($urandom);
		endcase
		write_reg(CFG_RANGE_FLOOR, lo);
		write_reg(CFG_RANGE_CEILING, hi);
		write_reg(CFG_ANGLE_START, {4'($urandom), start});
		write_reg(CFG_ANGLE_STEP, {4'($urandom), step});
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ANGLE_STEP) + 1,
			                                    (1 << CFG_IDX_W) - 1)),
			          CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return reg_floor;
			3: return reg_ceil;
			4: return reg_floor - 1'b1;
			5: return reg_ceil + 1'b1;
			6, 7: return RANGE_W'($urandom);
			default: begin
				if (reg_floor <= reg_ceil)
					return RANGE_W'($urandom_range(reg_floor, reg_ceil));
				return RANGE_W'($urandom);
			end
		endcase
	endfunction

	function automatic void check_report(input scan_report_t want, input scan_report_t got);
		for (int i = 0; i < OUT_SECTORS; i++) begin
			if (got.mins[i] !== want.mins[i]) begin
				errors++;
				$display("%0t: min_sector%0d expected %0d got %0d",
				         $realtime, i, want.mins[i], got.mins[i]);
			end
		end
		if (got.widest !== want.widest) begin
			errors++;
			$display("%0t: widest_sector expected %0d got %0d",
			         $realtime, want.widest, got.widest);
		end
		if (got.escape !== want.escape) begin
			errors++;
			$display("%0t: escape_left expected %0d got %0d",
			         $realtime, want.escape, got.escape);
		end
	endfunction

	// receiver: check reports, drive tready, honour hold-off requests
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (report_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected report, expected none got %h",
				         $realtime, m_axis_tdata);
			end else begin
				check_report(report_q.pop_front(), m_axis_tdata[$bits(scan_report_t)-1:0]);
			end
		end
		if (hold_flip != hold_seen) begin
			hold_seen <= hold_flip;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : stimulus
		plan_row_t    plan [$];
		scan_report_t rep_reset, rep_empty, rep_zero, rep_left;
		bit           prev_cfg;
		int           sent;
		int           len;
		bit           squeeze;

		reg_floor = '0;
		reg_ceil = '1;
		reg_start = ANGLE_W'(16'h8000);
		reg_step = ANGLE_W'(64);
		restart_scan();

		rep_reset = flat_report(SENTINEL_MM, WIDEST_W'(1), 1'b0);
		rep_reset.mins[0] = '0;
		rep_empty = flat_report(SENTINEL_MM, '0, 1'b0);
		rep_zero = flat_report('0, '0, 1'b0);
		rep_left = flat_report(SENTINEL_MM, '0, 1'b1);
		rep_left.mins[6] = RANGE_W'(7);

		// reset defaults put the first sample in sector 0
		plan.push_back(typed_row('0, 1'b1, 1'b1, rep_reset));
		// range above the sentinel leaves it alone
		plan.push_back(typed_row('1, 1'b1, 1'b1, rep_empty));
		plan.push_back(typed_row(RANGE_W'(5), 1'b0, 1'b1, rep_empty));
		// one sector per sample, zero everywhere
		plan.push_back(reg_row(CFG_ANGLE_STEP, CFG_DATA_W'(20'h02000)));
		for (int i = 0; i < OUT_SECTORS - 1; i++)
			plan.push_back(sample_row('0, 1'b1, 1'b0));
		plan.push_back(typed_row('0, 1'b1, 1'b1, rep_zero));
		// lone sample in sector 6 tips the escape flag
		plan.push_back(reg_row(CFG_ANGLE_START, CFG_DATA_W'(20'h04000)));
		plan.push_back(typed_row(RANGE_W'(7), 1'b1, 1'b1, rep_left));
		// window bounds, with a write to an unused index in between
		plan.push_back(reg_row(CFG_ANGLE_START, CFG_DATA_W'(20'h08000)));
		plan.push_back(reg_row(CFG_RANGE_FLOOR, CFG_DATA_W'(100)));
		plan.push_back(reg_row(CFG_RANGE_CEILING, CFG_DATA_W'(200)));
		plan.push_back(reg_row(CFG_UNUSED, '0));
		plan.push_back(sample_row(RANGE_W'(99), 1'b1, 1'b0));
		plan.push_back(sample_row(RANGE_W'(100), 1'b1, 1'b0));
		plan.push_back(sample_row(RANGE_W'(200), 1'b1, 1'b0));
		plan.push_back(sample_row(RANGE_W'(201), 1'b1, 1'b1));
		// inverted window drops everything
		plan.push_back(reg_row(CFG_RANGE_FLOOR, CFG_DATA_W'(500)));
		plan.push_back(reg_row(CFG_RANGE_CEILING, CFG_DATA_W'(400)));
		plan.push_back(typed_row(RANGE_W'(450), 1'b1, 1'b1, rep_empty));
		// angle wrap from the top of the range, junk in the upper data bits
		plan.push_back(reg_row(CFG_RANGE_FLOOR, '0));
		plan.push_back(reg_row(CFG_RANGE_CEILING, '1));
		plan.push_back(reg_row(CFG_ANGLE_START, CFG_DATA_W'(20'hF7FFF)));
		plan.push_back(reg_row(CFG_ANGLE_STEP, CFG_DATA_W'(20'h08000)));
		plan.push_back(sample_row(RANGE_W'(300), 1'b1, 1'b0));
		plan.push_back(sample_row(RANGE_W'(200), 1'b1, 1'b0));
		plan.push_back(sample_row(RANGE_W'(100), 1'b1, 1'b1));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 30;
		sink_idle_pct <= 87;
		prev_cfg = 1'b0;
		foreach (plan[n]) begin
			if (plan[n].is_cfg) begin
				if (!prev_cfg)
					settle();
				write_reg(plan[n].idx, plan[n].data);
			end else begin
				if (prev_cfg)
					cfg_valid <= 1'b0;
				push_sample(plan[n].range_mm, plan[n].finite, plan[n].last,
				            plan[n].typed, plan[n].want);
			end
			prev_cfg = plan[n].is_cfg;
		end

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct = 30;
					sink_idle_pct <= 87;
				end
				1: begin
					src_idle_pct = 87;
					sink_idle_pct <= 30;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct <= 0;
				end
			endcase
			for (int ph = 0; ph < 4; ph++) begin
				settle();
				randomise_regs();
				// hold the receiver off while short scans keep coming
				squeeze = (mode == 2 && ph == 0);
				if (squeeze)
					hold_flip <= ~hold_flip;
				sent = 0;
				while (sent < (squeeze ? PRESSURE_ITEMS : PHASE_ITEMS)) begin
					if (squeeze)
						len = $urandom_range(1, 3);
					else if ($urandom_range(0, 9) == 0)
						len = 1;
					else
						len = $urandom_range(2, 24);
					for (int k = 0; k < len; k++)
						push_sample(pick_range(), $urandom_range(0, 9) != 0,
						            k == len - 1, 1'b0, '0);
					sent += len;
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
